// ===== sv/qrs_pkg.sv =====
`default_nettype none

package qrs_pkg;

    // field widths
    localparam int COEF_W = 16;
    localparam int FRAC_W = 16;
    localparam int OUT_W  = 33;

    // internal widths at the fixed coefficient and fraction widths
    localparam int DMAG_W = 2 * COEF_W + 1;          // |b*b - 4ac|
    localparam int ROOT_W = DMAG_W;                  // sqrt of |D| << 2F
    localparam int NB_W   = COEF_W + FRAC_W + 1;     // -b << F
    localparam int DEN_W  = COEF_W + 2;              // 2a, signed
    localparam int NUM_W  = ROOT_W + 2;              // nb +/- s, signed
    localparam int DMAGN_W = DEN_W - 1;              // |2a|

    typedef enum logic [1:0] {
        KIND_DISTINCT = 2'd0,
        KIND_EQUAL    = 2'd1,
        KIND_COMPLEX  = 2'd2,
        KIND_INVALID  = 2'd3
    } root_kind_t;

    // carried alongside the square root pipeline
    typedef struct packed {
        root_kind_t              kind;
        logic signed [NB_W-1:0]  nb;
        logic signed [DEN_W-1:0] den;
    } sq_side_t;

    // carried alongside the divider pipelines
    typedef struct packed {
        root_kind_t kind;
        logic       neg;
    } div_side_t;

endpackage

`default_nettype wire

// ===== sv/quadratic_root_solver_unit.sv =====
// Quadratic root solver: roots of a*x^2 + b*x + c in signed Q16.16.
// Input channel s_*: one word carries coef_a, coef_b, coef_c (16-bit signed).
// Output channel m_*: tdata carries first_value and second_value (33-bit
// signed Q16.16), tuser carries root_kind (distinct, equal, complex, invalid).
// One result word leaves for every word accepted, in order.
// From acceptance to m_tvalid a word passes through the input register,
// multiply, discriminant, 33 square root stages (one root bit each),
// numerator stage, 35 divider stages (one quotient bit each, two dividers
// side by side) and the output register.
// Throughput: one word per cycle unless the output stalls; a new word may be accepted every cycle.
// The whole pipeline advances as one: when m_tvalid is high and m_tready is
// low, every stage holds and s_tready drops, so nothing is lost or repeated.
// s_tready is high whenever the output register is empty or being emptied.
// Reset (rst_n low, asynchronous) clears every stage valid bit; the pipeline
// then starts empty and accepts words in the first cycle after reset.
`default_nettype none

module quadratic_root_solver_unit
    import qrs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // coef_a [15:0], coef_b [31:16], coef_c [47:32]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // first_value [32:0], second_value [65:33], zero fill
    output logic [1:0]       m_tuser    // root_kind [1:0]
);

    localparam logic signed [NUM_W:0] SAT_HI = (NUM_W+1)'((64'd1 << (OUT_W - 1)) - 64'd1);
    localparam logic signed [NUM_W:0] SAT_LO = -SAT_HI - (NUM_W+1)'(1);

    logic ce;

    // global advance: all stages move when the output register can take a word
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    // input register
    logic                     v0_reg;
    logic signed [COEF_W-1:0] a0_reg, b0_reg, c0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (ce)
            v0_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            a0_reg <= s_tdata[15:0];
            b0_reg <= s_tdata[31:16];
            c0_reg <= s_tdata[47:32];
        end
    end

    // products b*b and a*c
    logic                       v1_reg;
    logic signed [2*COEF_W-1:0] bb1_reg, ac1_reg;
    logic signed [COEF_W-1:0]   a1_reg, b1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (ce)
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            bb1_reg <= b0_reg * b0_reg;
            ac1_reg <= a0_reg * c0_reg;
            a1_reg  <= a0_reg;
            b1_reg  <= b0_reg;
        end
    end

    // discriminant, root kind, -b << F and 2a
    logic signed [DMAG_W+1:0] disc;
    logic [DMAG_W+1:0]        disc_abs;
    logic signed [NB_W-1:0]   nb_next;
    logic signed [DEN_W-1:0]  den_next;
    root_kind_t               kind_next;

    assign disc     = $signed({{3{bb1_reg[2*COEF_W-1]}}, bb1_reg})
                    - $signed({ac1_reg[2*COEF_W-1], ac1_reg, 2'b00});
    assign disc_abs = disc[DMAG_W+1] ? (-disc) : disc;
    assign nb_next  = -$signed({b1_reg[COEF_W-1], b1_reg, {FRAC_W{1'b0}}});
    assign den_next = $signed({a1_reg[COEF_W-1], a1_reg, 1'b0});

    always_comb
    begin
        if (a1_reg == '0)
            kind_next = KIND_INVALID;
        else if (disc[DMAG_W+1])
            kind_next = KIND_COMPLEX;
        else if (disc == '0)
            kind_next = KIND_EQUAL;
        else
            kind_next = KIND_DISTINCT;
    end

    logic              v2_reg;
    logic [DMAG_W-1:0] dmag2_reg;
    sq_side_t          side2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (ce)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            dmag2_reg      <= disc_abs[DMAG_W-1:0];
            side2_reg.kind <= kind_next;
            side2_reg.nb   <= nb_next;
            side2_reg.den  <= den_next;
        end
    end

    // square root of |D| << 2F
    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    logic [$bits(sq_side_t)-1:0] sq_side_bits;
    sq_side_t          sq_side;

    qrs_sqrt_pipe #(
        .RW   (ROOT_W),
        .SB_W ($bits(sq_side_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (v2_reg),
        .radicand  ({1'b0, dmag2_reg, {(2*ROOT_W-DMAG_W-1){1'b0}}}),
        .in_side   (side2_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side_bits)
    );

    assign sq_side = sq_side_t'(sq_side_bits);

    // numerators as sign and magnitude
    logic signed [NUM_W-1:0] nb_ext, s_ext, n1, n2;
    logic [NUM_W-1:0]        n1_abs, n2_abs;
    logic [DEN_W-1:0]        den_abs;

    assign nb_ext  = $signed({{(NUM_W-NB_W){sq_side.nb[NB_W-1]}}, sq_side.nb});
    assign s_ext   = $signed({{(NUM_W-ROOT_W){1'b0}}, sq_root});
    assign n1      = (sq_side.kind == KIND_COMPLEX) ? nb_ext : (nb_ext + s_ext);
    assign n2      = (sq_side.kind == KIND_COMPLEX) ? s_ext : (nb_ext - s_ext);
    assign n1_abs  = n1[NUM_W-1] ? (-n1) : n1;
    assign n2_abs  = n2[NUM_W-1] ? (-n2) : n2;
    assign den_abs = sq_side.den[DEN_W-1] ? (-sq_side.den) : sq_side.den;

    logic               v3_reg;
    logic [NUM_W-1:0]   n1_3_reg, n2_3_reg;
    logic [DMAGN_W-1:0] den3_reg;
    div_side_t          side1_3_reg, side2_3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (ce)
            v3_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            n1_3_reg         <= n1_abs;
            n2_3_reg         <= n2_abs;
            den3_reg         <= den_abs[DMAGN_W-1:0];
            side1_3_reg.kind <= sq_side.kind;
            side1_3_reg.neg  <= n1[NUM_W-1] ^ sq_side.den[DEN_W-1];
            side2_3_reg.kind <= sq_side.kind;
            side2_3_reg.neg  <= n2[NUM_W-1] ^ sq_side.den[DEN_W-1];
        end
    end

    // two dividers by |2a|
    logic                         dv1_valid, dv2_valid;
    logic [NUM_W-1:0]             q1, q2;
    logic [$bits(div_side_t)-1:0] dv1_side_bits, dv2_side_bits;
    div_side_t                    dv1_side, dv2_side;

    qrs_div_pipe #(
        .NW   (NUM_W),
        .DW   (DMAGN_W),
        .SB_W ($bits(div_side_t))
    ) u_div_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (v3_reg),
        .num       (n1_3_reg),
        .den       (den3_reg),
        .in_side   (side1_3_reg),
        .out_valid (dv1_valid),
        .quot      (q1),
        .out_side  (dv1_side_bits)
    );

    qrs_div_pipe #(
        .NW   (NUM_W),
        .DW   (DMAGN_W),
        .SB_W ($bits(div_side_t))
    ) u_div_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (v3_reg),
        .num       (n2_3_reg),
        .den       (den3_reg),
        .in_side   (side2_3_reg),
        .out_valid (dv2_valid),
        .quot      (q2),
        .out_side  (dv2_side_bits)
    );

    assign dv1_side = div_side_t'(dv1_side_bits);
    assign dv2_side = div_side_t'(dv2_side_bits);

    // apply sign, saturate, zero for invalid
    logic signed [NUM_W:0] v1s, v2s, v1sat, v2sat;
    logic [OUT_W-1:0]      first_next, second_next;

    assign v1s   = dv1_side.neg ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
    assign v2s   = dv2_side.neg ? -$signed({1'b0, q2}) : $signed({1'b0, q2});
    assign v1sat = (v1s > SAT_HI) ? SAT_HI : ((v1s < SAT_LO) ? SAT_LO : v1s);
    assign v2sat = (v2s > SAT_HI) ? SAT_HI : ((v2s < SAT_LO) ? SAT_LO : v2s);

    assign first_next  = (dv1_side.kind == KIND_INVALID) ? '0 : v1sat[OUT_W-1:0];
    assign second_next = (dv1_side.kind == KIND_INVALID) ? '0 : v2sat[OUT_W-1:0];

    // output register
    logic             out_v_reg;
    logic [OUT_W-1:0] first_reg, second_reg;
    root_kind_t       kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (ce)
            out_v_reg <= dv1_valid && dv2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
            kind_reg   <= dv1_side.kind;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {{(72-2*OUT_W){1'b0}}, second_reg, first_reg};
    assign m_tuser  = kind_reg;

`ifndef ASSERT_OFF
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_INVALID) |-> (m_tdata == '0))
        else $error("invalid result carries nonzero values");

    a_equal_same: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_EQUAL) |-> (first_reg == second_reg))
        else $error("repeated root differs between fields");

    a_dividers_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        dv1_valid == dv2_valid)
        else $error("divider pipelines out of step");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !ce |=> ($stable(v3_reg) && $stable(v2_reg)))
        else $error("pipeline moved during stall");
`endif

endmodule

`default_nettype wire

// ===== sv/qrs_sqrt_pipe.sv =====
`default_nettype none

module qrs_sqrt_pipe
    import qrs_pkg::*;
#(
    parameter int RW   = ROOT_W,
    parameter int SB_W = $bits(sq_side_t)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              ce,
    input  wire logic              in_valid,
    input  wire logic [2*RW-1:0]   radicand,
    input  wire logic [SB_W-1:0]   in_side,
    output logic                   out_valid,
    output logic [RW-1:0]          root,
    output logic [SB_W-1:0]        out_side
);

    // one result bit per stage
    logic [RW+2:0]   rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [2*RW-1:0] rad_reg  [RW];
    logic [SB_W-1:0] side_reg [RW];
    logic            vld_reg  [RW];

    for (genvar i = 0; i < RW; i++) begin : g_stage
        logic [RW+2:0]   rem_in;
        logic [RW-1:0]   root_in;
        logic [2*RW-1:0] rad_in;
        logic [SB_W-1:0] side_in;
        logic            vld_in;
        logic [RW+2:0]   cur;
        logic [RW+2:0]   trial;
        logic            ge;

        if (i == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = radicand;
            assign side_in = in_side;
            assign vld_in  = in_valid;
        end
        else begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign rad_in  = rad_reg[i-1];
            assign side_in = side_reg[i-1];
            assign vld_in  = vld_reg[i-1];
        end

        // bring down two radicand bits and try the next root bit
        assign cur   = {rem_in[RW:0], rad_in[2*RW-1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign ge    = (cur >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (ce)
                vld_reg[i] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[i]  <= ge ? (cur - trial) : cur;
                root_reg[i] <= {root_in[RW-2:0], ge};
                rad_reg[i]  <= {rad_in[2*RW-3:0], 2'b00};
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign out_side  = side_reg[RW-1];

endmodule

`default_nettype wire

// ===== sv/qrs_div_pipe.sv =====
`default_nettype none

module qrs_div_pipe
    import qrs_pkg::*;
#(
    parameter int NW   = NUM_W,
    parameter int DW   = DMAGN_W,
    parameter int SB_W = $bits(div_side_t)
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            ce,
    input  wire logic            in_valid,
    input  wire logic [NW-1:0]   num,
    input  wire logic [DW-1:0]   den,
    input  wire logic [SB_W-1:0] in_side,
    output logic                 out_valid,
    output logic [NW-1:0]        quot,
    output logic [SB_W-1:0]      out_side
);

    // restoring division, one quotient bit per stage
    logic [DW-1:0]   rem_reg  [NW];
    logic [NW-1:0]   q_reg    [NW];
    logic [NW-1:0]   num_reg  [NW];
    logic [DW-1:0]   den_reg  [NW];
    logic [SB_W-1:0] side_reg [NW];
    logic            vld_reg  [NW];

    for (genvar i = 0; i < NW; i++) begin : g_stage
        logic [DW-1:0]   rem_in;
        logic [NW-1:0]   q_in;
        logic [NW-1:0]   num_in;
        logic [DW-1:0]   den_in;
        logic [SB_W-1:0] side_in;
        logic            vld_in;
        logic [DW:0]     cur;
        logic [DW:0]     diff;
        logic            ge;

        if (i == 0) begin : g_first
            assign rem_in  = '0;
            assign q_in    = '0;
            assign num_in  = num;
            assign den_in  = den;
            assign side_in = in_side;
            assign vld_in  = in_valid;
        end
        else begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign q_in    = q_reg[i-1];
            assign num_in  = num_reg[i-1];
            assign den_in  = den_reg[i-1];
            assign side_in = side_reg[i-1];
            assign vld_in  = vld_reg[i-1];
        end

        // shift in the next numerator bit and subtract if it fits
        assign cur  = {rem_in, num_in[NW-1]};
        assign ge   = (cur >= {1'b0, den_in});
        assign diff = cur - {1'b0, den_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (ce)
                vld_reg[i] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[i]  <= ge ? diff[DW-1:0] : cur[DW-1:0];
                q_reg[i]    <= {q_in[NW-2:0], ge};
                num_reg[i]  <= {num_in[NW-2:0], 1'b0};
                den_reg[i]  <= den_in;
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[NW-1];
    assign quot      = q_reg[NW-1];
    assign out_side  = side_reg[NW-1];

endmodule

`default_nettype wire
